// File: rtl/core/bcrp_pkg.sv
// ----------------------------------------------------------------------------
// bcrp_pkg
// Shared types, constants and helpers of the blank column/row profile block.
// ----------------------------------------------------------------------------
package bcrp_pkg;

  // Field and register widths fixed by the interface.
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned PROD_W  = COUNT_W + 5;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  // Depth of the queue between front and back, and of the result buffer.
  // The result buffer depth must be a power of two.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned OUT_DEPTH   = 4;

  // Blank thresholds: count * 25 < width for rows, count * 10 < height for columns.
  localparam int unsigned ROW_MUL = 25;
  localparam int unsigned COL_MUL = 10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = CFG_W'(1024);
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = CFG_W'(1024);
  localparam logic [CFG_W-1:0] RST_SPAN_START   = CFG_W'(0);
  localparam logic [CFG_W-1:0] RST_SPAN_END     = CFG_W'(1024);

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_SPAN_START   = 2'd2,
    REG_SPAN_END     = 2'd3
  } cfg_reg_e;

  localparam logic KIND_COLUMN = 1'b0;
  localparam logic KIND_ROW    = 1'b1;

  typedef struct packed {
    logic dark;
    logic first_row;
    logic last_row;
    logic end_row;
    logic row_blank;
  } item_flags_t;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] pos;
    logic             blank;
    logic             last;
  } result_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_W'(1);
  endfunction

endpackage

// File: rtl/core/bcrp_queue.sv
// ----------------------------------------------------------------------------
// bcrp_queue
// Small register FIFO that decouples the classifying front from the back.
// ----------------------------------------------------------------------------
module bcrp_queue import bcrp_pkg::*; #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output logic          full_o,
  output logic [DW-1:0] data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [NW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == NW'(DEPTH));
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
      end
      if (do_pop) begin
        rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
      end
      cnt_q <= cnt_q + NW'(do_push) - NW'(do_pop);
    end
  end

endmodule

// File: rtl/core/bcrp_front.sv
// ----------------------------------------------------------------------------
// bcrp_front
// Holds the configuration, tracks column/row position and the row dark count,
// and classifies each accepted pixel for the back end.
// ----------------------------------------------------------------------------
module bcrp_front import bcrp_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [CFG_W-1:0]                  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [PIX_W-1:0]                  pixel_gray_i,
  input  logic                              hold_i,
  input  logic                              q_full_i,
  output logic                              push_o,
  output logic [$clog2(MAX_WIDTH)-1:0]      col_o,
  output logic [$clog2(MAX_HEIGHT)-1:0]     row_o,
  output item_flags_t                       flags_o,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]   h_clamp_o
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned RW   = $clog2(MAX_HEIGHT);
  localparam int unsigned WBW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HBW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CMPW = (CW > CFG_W) ? CW : CFG_W;

  logic [CFG_W-1:0]   width_q, height_q, span_start_q, span_end_q;
  logic [CW-1:0]      col_q;
  logic [RW-1:0]      row_q;
  logic [COUNT_W-1:0] rdc_q, rdc_new;
  logic [WBW-1:0]     w_cl;
  logic [HBW-1:0]     h_cl;
  logic [CW-1:0]      w_last;
  logic [RW-1:0]      h_last;
  logic               dark, in_span, end_row, last_row, row_blank;

  // Geometry is clamped to [1, MAX].
  always_comb begin
    if (width_q == '0) begin
      w_cl = WBW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_cl = WBW'(MAX_WIDTH);
    end else begin
      w_cl = WBW'(width_q);
    end
    if (height_q == '0) begin
      h_cl = HBW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_cl = HBW'(MAX_HEIGHT);
    end else begin
      h_cl = HBW'(height_q);
    end
  end

  assign w_last = CW'(w_cl - WBW'(1));
  assign h_last = RW'(h_cl - HBW'(1));

  assign dark     = (pixel_gray_i == '0);
  assign end_row  = (col_q >= w_last);
  assign last_row = (row_q >= h_last);
  assign in_span  = (CMPW'(col_q) >= CMPW'(span_start_q)) &&
                    (CMPW'(col_q) < CMPW'(span_end_q));
  assign rdc_new  = (dark && in_span) ? sat_inc(rdc_q) : rdc_q;
  assign row_blank = (PROD_W'(rdc_new) * PROD_W'(ROW_MUL)) < PROD_W'(w_cl);

  assign in_ready_o = !hold_i && !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;
  assign col_o      = col_q;
  assign row_o      = row_q;
  assign h_clamp_o  = h_cl;

  always_comb begin
    flags_o.dark      = dark;
    flags_o.first_row = (row_q == '0);
    flags_o.last_row  = last_row;
    flags_o.end_row   = end_row;
    flags_o.row_blank = row_blank;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= RST_IMAGE_WIDTH;
      height_q     <= RST_IMAGE_HEIGHT;
      span_start_q <= RST_SPAN_START;
      span_end_q   <= RST_SPAN_END;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  width_q      <= cfg_data_i;
        REG_IMAGE_HEIGHT: height_q     <= cfg_data_i;
        REG_SPAN_START:   span_start_q <= cfg_data_i;
        REG_SPAN_END:     span_end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      rdc_q <= '0;
    end else if (push_o) begin
      if (end_row) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + RW'(1);
        rdc_q <= '0;
      end else begin
        col_q <= col_q + CW'(1);
        rdc_q <= rdc_new;
      end
    end
  end

endmodule

// File: rtl/core/bcrp_back.sv
// ----------------------------------------------------------------------------
// bcrp_back
// Column count memory with read-modify-write, blank tests and result buffer.
// ----------------------------------------------------------------------------
module bcrp_back import bcrp_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  output logic                              q_pop_o,
  input  logic [$clog2(MAX_WIDTH)-1:0]      q_col_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0]     q_row_i,
  input  item_flags_t                       q_flags_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   h_clamp_i,
  output logic                              busy_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output result_t                           result_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned OPW = $clog2(OUT_DEPTH);
  localparam int unsigned OCW = $clog2(OUT_DEPTH + 1);

  // Column dark counts; contents are swept to zero after reset.
  logic [COUNT_W-1:0] cnt_mem [MAX_WIDTH];

  logic               clr_busy_q;
  logic [CW-1:0]      clr_idx_q;

  logic               ex_valid_q;
  logic [CW-1:0]      ex_col_q;
  logic [RW-1:0]      ex_row_q;
  item_flags_t        ex_flags_q;
  logic [COUNT_W-1:0] rd_q, fwd_data_q;
  logic               fwd_hit_q;

  result_t            obuf_q [OUT_DEPTH];
  logic [OPW-1:0]     owp_q, orp_q;
  logic [OCW-1:0]     ocnt_q;

  logic [COUNT_W-1:0] base, cnt_new, mem_wdata;
  logic [CW-1:0]      mem_waddr;
  logic               mem_we, col_blank, space_ok, ex_done, take, out_pop;
  logic [1:0]         n_res;
  result_t            res_col, res_row, res_first;

  // The previous item's write lands in the same cycle as this item's read,
  // so that value is forwarded when both hit the same column.
  assign base    = ex_flags_q.first_row ? '0 : (fwd_hit_q ? fwd_data_q : rd_q);
  assign cnt_new = ex_flags_q.dark ? sat_inc(base) : base;
  assign col_blank = (PROD_W'(cnt_new) * PROD_W'(COL_MUL)) < PROD_W'(h_clamp_i);

  assign n_res    = {1'b0, ex_flags_q.last_row} + {1'b0, ex_flags_q.end_row};
  assign space_ok = (ocnt_q + OCW'(n_res)) <= OCW'(OUT_DEPTH);
  assign ex_done  = ex_valid_q && space_ok;
  assign take     = q_valid_i && !clr_busy_q && (!ex_valid_q || ex_done);
  assign q_pop_o  = take;
  assign busy_o   = clr_busy_q;

  assign mem_we    = clr_busy_q || ex_done;
  assign mem_waddr = clr_busy_q ? clr_idx_q : ex_col_q;
  assign mem_wdata = clr_busy_q ? '0 : cnt_new;

  always_comb begin
    res_col.kind  = KIND_COLUMN;
    res_col.pos   = POS_W'(ex_col_q);
    res_col.blank = col_blank;
    res_col.last  = !ex_flags_q.end_row;
    res_row.kind  = KIND_ROW;
    res_row.pos   = POS_W'(ex_row_q);
    res_row.blank = ex_flags_q.row_blank;
    res_row.last  = 1'b1;
    res_first     = ex_flags_q.last_row ? res_col : res_row;
  end

  assign out_valid_o = (ocnt_q != '0);
  assign result_o    = obuf_q[orp_q];
  assign out_pop     = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cnt_mem[mem_waddr] <= mem_wdata;
    end
    if (take) begin
      rd_q       <= cnt_mem[q_col_i];
      fwd_data_q <= cnt_new;
      ex_col_q   <= q_col_i;
      ex_row_q   <= q_row_i;
      ex_flags_q <= q_flags_i;
    end
    if (ex_done && (n_res != 2'd0)) begin
      obuf_q[owp_q] <= res_first;
      if (n_res == 2'd2) begin
        obuf_q[owp_q + OPW'(1)] <= res_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
      ex_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
      owp_q      <= '0;
      orp_q      <= '0;
      ocnt_q     <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + CW'(1);
        if (clr_idx_q == CW'(MAX_WIDTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (take) begin
        ex_valid_q <= 1'b1;
        fwd_hit_q  <= ex_done && (ex_col_q == q_col_i);
      end else if (ex_done) begin
        ex_valid_q <= 1'b0;
      end
      if (ex_done) begin
        owp_q <= owp_q + OPW'(n_res);
      end
      if (out_pop) begin
        orp_q <= orp_q + OPW'(1);
      end
      ocnt_q <= ocnt_q + (ex_done ? OCW'(n_res) : '0) - OCW'(out_pop);
    end
  end

endmodule

// File: rtl/core/blank_column_row_profile_top.sv
// ----------------------------------------------------------------------------
// blank_column_row_profile_top
// Blank row and column detection by dark pixel projection profiles.
//
//   channel  direction  beat contents
//   in       input      pixel_gray_i
//   out      output     result_kind_o, position_o, is_blank_o, last_o
//   cfg      input      cfg_idx_i, cfg_data_i (write only, no handshake back)
//
// One pixel is accepted per cycle in steady state; a result is presented from
// the result buffer once its pixel has passed the queue and the execute stage.
// The column count memory has one read and one write per cycle, which sets
// that rate. The last pixel of the last row gives two result beats. After
// reset, a clearing pass over every column zeroes the column counts and holds
// in_ready_o low. Output stalls back up through the result buffer and the
// queue into in_ready_o.
// ----------------------------------------------------------------------------
module blank_column_row_profile_top import bcrp_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [PIX_W-1:0] pixel_gray_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             result_kind_o,
  output logic [POS_W-1:0] position_o,
  output logic             is_blank_o,
  output logic             last_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned HBW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned FW  = $bits(item_flags_t);
  localparam int unsigned DW  = CW + RW + FW;

  logic              push, q_full, q_valid, q_pop, busy;
  logic [CW-1:0]     f_col, q_col;
  logic [RW-1:0]     f_row, q_row;
  item_flags_t       f_flags, q_flags;
  logic [HBW-1:0]    h_clamp;
  logic [DW-1:0]     q_data;
  result_t           result;

  bcrp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_gray_i (pixel_gray_i),
    .hold_i       (busy),
    .q_full_i     (q_full),
    .push_o       (push),
    .col_o        (f_col),
    .row_o        (f_row),
    .flags_o      (f_flags),
    .h_clamp_o    (h_clamp)
  );

  bcrp_queue #(
    .DW    (DW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_col, f_row, f_flags}),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .data_o  (q_data)
  );

  assign q_col   = q_data[DW-1 -: CW];
  assign q_row   = q_data[FW+RW-1 -: RW];
  assign q_flags = item_flags_t'(q_data[FW-1:0]);

  bcrp_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_col_i     (q_col),
    .q_row_i     (q_row),
    .q_flags_i   (q_flags),
    .h_clamp_i   (h_clamp),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign result_kind_o = result.kind;
  assign position_o    = result.pos;
  assign is_blank_o    = result.blank;
  assign last_o        = result.last;

endmodule

// File: rtl/core/bcrp_checker.sv
// ----------------------------------------------------------------------------
// bcrp_checker
// Port-level checks of the blank column/row profile block, bound to the top.
// ----------------------------------------------------------------------------
module bcrp_checker import bcrp_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic             result_kind_o,
  input logic [POS_W-1:0] position_o,
  input logic             is_blank_o,
  input logic             last_o
);

  // Set after a column beat that is not the last of its pixel.
  logic pend_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_row_q <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      pend_row_q <= (result_kind_o == KIND_COLUMN) && !last_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o) &&
      $stable(position_o) && $stable(is_blank_o) && $stable(last_o))
    else $error("output beat changed while stalled");

  a_row_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KIND_ROW) |-> last_o)
    else $error("row report without last");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pend_row_q |-> (result_kind_o == KIND_ROW))
    else $error("column report not followed by its row report");

  a_clear_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_o)
    else $error("pixel accepted before the count memory was cleared");

endmodule

bind blank_column_row_profile_top bcrp_checker u_bcrp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_kind_o (result_kind_o),
  .position_o    (position_o),
  .is_blank_o    (is_blank_o),
  .last_o        (last_o)
);

// File: tb/blank_column_row_profile_top_test.sv
// ----------------------------------------------------------------------------
// blank_column_row_profile_top_test
// Drives grayscale frames into the blank row/column profiler and checks every
// report beat against a cycle-free predictor of the dark-pixel projection
// counts. A short table of hand-picked pixels and register writes comes first,
// then randomized frames under changing geometry, span and idle patterns.
// ----------------------------------------------------------------------------
module blank_column_row_profile_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bcrp_pkg::*;

  localparam int unsigned ITEM_GOAL     = 2000;
  localparam int unsigned PHASE_CAP     = 400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // One line of the directed table: either a register write or a pixel,
  // optionally with its report beats spelled out by hand.
  typedef struct packed {
    logic             is_cfg;
    cfg_reg_e         sel;
    logic [CFG_W-1:0] value;
    logic [PIX_W-1:0] pix;
    logic             typed;
    logic [1:0]       n_typed;
    result_t          first_rep;
    result_t          second_rep;
  } stim_row_t;

  localparam result_t NO_REP = '0;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [PIX_W-1:0] pixel_gray_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic             result_kind_o;
  logic [POS_W-1:0] position_o;
  logic             is_blank_o;
  logic             last_o;

  blank_column_row_profile_top dut (.*);

  // Predictor state: register shadows and the projection counts.
  logic [CFG_W-1:0]   frame_width;
  logic [CFG_W-1:0]   frame_height;
  logic [CFG_W-1:0]   span_first;
  logic [CFG_W-1:0]   span_stop;
  logic [COUNT_W-1:0] col_darks [DEF_MAX_WIDTH];
  logic [COUNT_W-1:0] row_darks;
  int unsigned        cur_col;
  int unsigned        cur_row;

  result_t     pending_reports [$];
  stim_row_t   directed_rows [$];
  int unsigned send_idle_pct;
  int unsigned take_stall_pct;
  int unsigned pixels_sent;
  int unsigned report_beats;
  int unsigned cfg_writes;
  int unsigned error_count;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("blank_column_row_profile_top_test: errors");
    $finish;
  end

  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
    if (v == '0) return 1;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic result_t rep(logic kind, int unsigned pos, logic blank);
    result_t r;
    r.kind  = kind;
    r.pos   = POS_W'(pos);
    r.blank = blank;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(cfg_reg_e sel, int unsigned value);
    stim_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.sel    = sel;
    r.value  = CFG_W'(value);
    return r;
  endfunction

  function automatic stim_row_t pix_row(logic [PIX_W-1:0] pix);
    stim_row_t r;
    r     = '0;
    r.pix = pix;
    return r;
  endfunction

  function automatic stim_row_t chk_row(logic [PIX_W-1:0] pix, int n, result_t a, result_t b);
    stim_row_t r;
    r         = pix_row(pix);
    r.typed   = 1'b1;
    r.n_typed = 2'(n);
    if (n == 1) a.last = 1'b1;
    if (n == 2) b.last = 1'b1;
    r.first_rep  = a;
    r.second_rep = b;
    return r;
  endfunction

  // Advances the projection counts by one pixel and returns its report beats.
  // The column report, when there is one, precedes the row report.
  task automatic predict_reports(input logic [PIX_W-1:0] pix, output result_t r0,
                                 output result_t r1, output int n);
    int unsigned        w;
    int unsigned        h;
    logic [COUNT_W-1:0] c;
    logic               dark;
    logic               row_end;
    logic               final_row;
    result_t            row_rep;
    w         = clamp_dim(frame_width, DEF_MAX_WIDTH);
    h         = clamp_dim(frame_height, DEF_MAX_HEIGHT);
    dark      = (pix == '0);
    row_end   = (cur_col >= w - 1);
    final_row = (cur_row >= h - 1);
    n         = 0;
    r0        = NO_REP;
    r1        = NO_REP;
    if (cur_col < DEF_MAX_WIDTH) begin
      // Row 0 starts a fresh frame, so the stored count is dropped.
      c = (cur_row == 0) ? '0 : col_darks[cur_col];
      if (dark && c != COUNT_MAX) c = c + 1'b1;
      col_darks[cur_col] = c;
      if (final_row) begin
        r0 = rep(KIND_COLUMN, cur_col, int'(c) * 10 < h);
        n  = 1;
      end
    end
    if (dark && cur_col >= span_first && cur_col < span_stop && row_darks != COUNT_MAX)
      row_darks = row_darks + 1'b1;
    if (row_end) begin
      row_rep = rep(KIND_ROW, cur_row, int'(row_darks) * 25 < w);
      if (n == 0) r0 = row_rep;
      else r1 = row_rep;
      n++;
      row_darks = '0;
      cur_col   = 0;
      cur_row   = final_row ? 0 : cur_row + 1;
    end else begin
      cur_col++;
    end
    if (n == 1) r0.last = 1'b1;
    if (n == 2) r1.last = 1'b1;
  endtask

  task automatic write_register(input cfg_reg_e sel, input int unsigned value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= CFG_W'(value);
    case (sel)
      REG_IMAGE_WIDTH:  frame_width  = CFG_W'(value);
      REG_IMAGE_HEIGHT: frame_height = CFG_W'(value);
      REG_SPAN_START:   span_first   = CFG_W'(value);
      REG_SPAN_END:     span_stop    = CFG_W'(value);
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Holds the pixel stream until every pending report has come back, then
  // waits out the pipeline for pixels that produce no report.
  task automatic wait_reports_drained();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_pixel(input stim_row_t row);
    int      g;
    int      np;
    result_t p0;
    result_t p1;
    g = 0;
    while (g < 30 && $urandom_range(0, 99) < send_idle_pct) g++;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pixel_gray_i <= row.pix;
    do @(posedge clk_i); while (!in_ready_o);
    predict_reports(row.pix, p0, p1, np);
    if (row.typed) begin
      if (row.n_typed > 0) pending_reports.push_back(row.first_rep);
      if (row.n_typed > 1) pending_reports.push_back(row.second_rep);
    end else begin
      if (np > 0) pending_reports.push_back(p0);
      if (np > 1) pending_reports.push_back(p1);
    end
    pixels_sent++;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Report side: checks each beat and throttles out_ready_i.
  initial begin
    result_t want;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_reports.size() == 0) begin
          $error("report beat with none pending: kind %0d position %0d",
                 result_kind_o, position_o);
          error_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("result_kind", 32'(want.kind), 32'(result_kind_o));
          check_field("position", 32'(want.pos), 32'(position_o));
          check_field("is_blank", 32'(want.blank), 32'(is_blank_o));
          check_field("last", 32'(want.last), 32'(last_o));
        end
        report_beats++;
      end
      out_ready_i <= ($urandom_range(0, 99) >= take_stall_pct);
    end
  end

  initial begin
    int unsigned      phase;
    int unsigned      random_items;
    int unsigned      n_items;
    int unsigned      dark_pct;
    int unsigned      w_set;
    int unsigned      h_set;
    int unsigned      wc;
    int unsigned      hc;
    int unsigned      lo;
    int unsigned      hi;
    logic             extreme;
    logic [PIX_W-1:0] pix;

    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= REG_IMAGE_WIDTH;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    pixel_gray_i <= '0;
    frame_width    = RST_IMAGE_WIDTH;
    frame_height   = RST_IMAGE_HEIGHT;
    span_first     = RST_SPAN_START;
    span_stop      = RST_SPAN_END;
    row_darks      = '0;
    cur_col        = 0;
    cur_row        = 0;
    send_idle_pct  = 0;
    take_stall_pct = 0;
    pixels_sent    = 0;
    report_beats   = 0;
    cfg_writes     = 0;
    error_count    = 0;
    foreach (col_darks[i]) col_darks[i] = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed_rows = {
      // 3x2 frame with a span wider than any row.
      cfg_row(REG_IMAGE_WIDTH, 3),
      cfg_row(REG_IMAGE_HEIGHT, 2),
      cfg_row(REG_SPAN_END, 2047),
      chk_row(8'd0, 0, NO_REP, NO_REP),
      chk_row(8'd255, 0, NO_REP, NO_REP),
      chk_row(8'd0, 1, rep(KIND_ROW, 0, 1'b0), NO_REP),
      pix_row(8'd1),
      pix_row(8'd128),
      pix_row(8'd0),
      // Zero geometry clamps to a single pixel: every pixel reports twice.
      cfg_row(REG_IMAGE_WIDTH, 0),
      cfg_row(REG_IMAGE_HEIGHT, 0),
      chk_row(8'd0, 2, rep(KIND_COLUMN, 0, 1'b0), rep(KIND_ROW, 0, 1'b0)),
      chk_row(8'd255, 2, rep(KIND_COLUMN, 0, 1'b1), rep(KIND_ROW, 0, 1'b1)),
      // Inverted, then empty span: the row count stays at zero.
      cfg_row(REG_SPAN_START, 2047),
      cfg_row(REG_SPAN_END, 0),
      chk_row(8'd0, 2, rep(KIND_COLUMN, 0, 1'b0), rep(KIND_ROW, 0, 1'b1)),
      cfg_row(REG_SPAN_START, 0),
      chk_row(8'd0, 2, rep(KIND_COLUMN, 0, 1'b0), rep(KIND_ROW, 0, 1'b1)),
      // Oversized width, one row, then the width shrinks under the row.
      cfg_row(REG_SPAN_END, 1024),
      cfg_row(REG_IMAGE_WIDTH, 2047),
      cfg_row(REG_IMAGE_HEIGHT, 1),
      chk_row(8'd0, 1, rep(KIND_COLUMN, 0, 1'b0), NO_REP),
      chk_row(8'd254, 1, rep(KIND_COLUMN, 1, 1'b1), NO_REP),
      pix_row(8'd0),
      pix_row(8'd0),
      cfg_row(REG_IMAGE_WIDTH, 2),
      pix_row(8'd64),
      // The height shrinks below the current row, which becomes the last.
      cfg_row(REG_IMAGE_HEIGHT, 5),
      pix_row(8'd0),
      pix_row(8'd127),
      pix_row(8'd0),
      pix_row(8'd0),
      cfg_row(REG_IMAGE_HEIGHT, 2),
      pix_row(8'd0),
      pix_row(8'd1)
    };

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_reports_drained();
        write_register(directed_rows[i].sel, 32'(directed_rows[i].value));
      end else begin
        send_pixel(directed_rows[i]);
      end
    end

    phase        = 0;
    random_items = 0;
    while (random_items < ITEM_GOAL || phase < 5) begin
      wait_reports_drained();
      send_idle_pct  = (phase % 4 == 1) ? 46 : (phase % 4 == 3) ? 22 : 0;
      take_stall_pct = (phase % 4 == 2) ? 46 : (phase % 4 == 3) ? 22 : 0;
      extreme = (phase == 1 || phase == 4);

      // Mostly small frames; some tall ones for the column threshold, some
      // wide ones for the row threshold, a few with zero geometry.
      if (phase == 1) begin
        w_set = 2047;
        h_set = 1;
      end else if (phase == 4) begin
        w_set = 1;
        h_set = 2047;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            w_set = $urandom_range(1, 12);
            h_set = $urandom_range(1, 8);
          end
          5, 6: begin
            w_set = $urandom_range(1, 6);
            h_set = $urandom_range(10, 30);
          end
          7, 8: begin
            w_set = $urandom_range(25, 80);
            h_set = $urandom_range(1, 3);
          end
          default: begin
            w_set = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
            h_set = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
          end
        endcase
      end
      write_register(REG_IMAGE_WIDTH, w_set);
      write_register(REG_IMAGE_HEIGHT, h_set);
      wc = clamp_dim(CFG_W'(w_set), DEF_MAX_WIDTH);
      hc = clamp_dim(CFG_W'(h_set), DEF_MAX_HEIGHT);

      case ($urandom_range(0, 3))
        0: begin
          lo = 0;
          hi = 2047;
        end
        1: begin
          lo = $urandom_range(0, wc);
          hi = $urandom_range(lo, wc + 1);
        end
        2: begin
          lo = $urandom_range(0, wc + 2);
          hi = $urandom_range(0, wc + 2);
        end
        default: begin
          lo = $urandom_range(0, 1) ? 0 : 2047;
          hi = $urandom_range(0, 1) ? 1024 : 0;
        end
      endcase
      write_register(REG_SPAN_START, lo);
      write_register(REG_SPAN_END, hi);

      case ($urandom_range(0, 5))
        0: dark_pct = 0;
        1: dark_pct = 3;
        2: dark_pct = 10;
        3: dark_pct = 30;
        4: dark_pct = 70;
        default: dark_pct = 100;
      endcase

      // Whole frames plus a ragged tail, so the next setting lands mid-frame.
      if (extreme) begin
        n_items = wc * hc + $urandom_range(0, 16);
      end else begin
        n_items = wc * hc * $urandom_range(1, 3) + $urandom_range(0, wc);
        if (n_items > PHASE_CAP) n_items = PHASE_CAP;
      end

      for (int unsigned k = 0; k < n_items; k++) begin
        if (k == n_items / 2 && $urandom_range(0, 2) == 0) wait_reports_drained();
        pix = ($urandom_range(0, 99) < dark_pct) ? '0 : PIX_W'($urandom_range(1, 255));
        send_pixel(pix_row(pix));
      end
      random_items += n_items;
      phase++;
    end

    wait_reports_drained();
    $display("%0d pixels over %0d random phases, %0d report beats checked, %0d register writes",
             pixels_sent, phase, report_beats, cfg_writes);
    $display("geometry from zero to oversized, inverted and empty spans, with and without idling");
    if (error_count == 0) begin
      $display("blank_column_row_profile_top_test: clean");
    end else begin
      $display("blank_column_row_profile_top_test: errors");
    end
    $finish;
  end

endmodule
